[rtl/sorted_table_binary_search_assert.svh]
// Assertion macros for the checker file of the sorted table search.
`ifndef SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define STBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define STBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/stbs_pkg.sv]
// Shared constants and types of the sorted table search block.
`default_nettype none
package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int VALUE_W     = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = ADDR_W + 1;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  // Register index is paddr[2]; only register 0 exists
  localparam logic REG_ENTRY_COUNT = 1'b0;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] position;
  } stbs_result_t;

endpackage
`default_nettype wire

[rtl/stbs_ram.sv]
// Generic single-clock RAM, one write port and one registered read port.
`default_nettype none
module stbs_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[rtl/stbs_search.sv]
// Binary search sequencer: one table probe per cycle against the RAM read port.
`default_nettype none
module stbs_search import stbs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               req,
  input  wire logic [VALUE_W-1:0] key,
  input  wire logic [COUNT_W-1:0] count,
  output logic      [ADDR_W-1:0]  rd_addr,
  input  wire logic [VALUE_W-1:0] rd_data,
  output logic                    busy,
  output logic                    res_valid,
  output stbs_result_t            res
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SEARCH = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [COUNT_W-1:0] lo_r, lo_nxt;
  logic [COUNT_W-1:0] hi_r, hi_nxt;   // exclusive upper bound
  logic [ADDR_W-1:0]  mid_r, mid_nxt;
  logic [VALUE_W-1:0] key_r, key_nxt;
  logic               valid_r, valid_nxt;
  stbs_result_t       res_r, res_nxt;
  logic [COUNT_W-1:0] lo_upd, hi_upd;

  // floor((lo + hi_incl) / 2) with hi_incl = hi - 1
  function automatic logic [ADDR_W-1:0] mid_of(input logic [COUNT_W-1:0] lo,
                                               input logic [COUNT_W-1:0] hi);
    logic [COUNT_W:0] sum;
    sum = {1'b0, lo} + {1'b0, hi} - {{COUNT_W{1'b0}}, 1'b1};
    return sum[ADDR_W:1];
  endfunction

  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    key_nxt   = key_r;
    valid_nxt = 1'b0;
    res_nxt   = res_r;
    lo_upd    = lo_r;
    hi_upd    = hi_r;
    rd_addr   = mid_r;
    case (state_r)
      ST_IDLE: begin
        rd_addr = mid_of('0, count);
        if (req) begin
          state_nxt = ST_SEARCH;
          lo_nxt    = '0;
          hi_nxt    = count;
          mid_nxt   = rd_addr;
          key_nxt   = key;
        end
      end
      ST_SEARCH: begin
        if (lo_r >= hi_r) begin
          // range exhausted: report a miss
          state_nxt    = ST_IDLE;
          valid_nxt    = 1'b1;
          res_nxt      = '0;
        end else if (rd_data == key_r) begin
          state_nxt    = ST_IDLE;
          valid_nxt    = 1'b1;
          res_nxt.found    = 1'b1;
          res_nxt.position = mid_r;
        end else begin
          if ($signed(rd_data) > $signed(key_r)) begin
            hi_upd = {1'b0, mid_r};
          end else begin
            lo_upd = {1'b0, mid_r} + {{ADDR_W{1'b0}}, 1'b1};
          end
          lo_nxt  = lo_upd;
          hi_nxt  = hi_upd;
          // issue the next probe straight away
          rd_addr = mid_of(lo_upd, hi_upd);
          mid_nxt = rd_addr;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    key_r <= key_nxt;
    res_r <= res_nxt;
  end

  assign busy      = (state_r == ST_SEARCH);
  assign res_valid = valid_r;
  assign res       = res_r;

endmodule
`default_nettype wire

[rtl/sorted_table_binary_search.sv]
// Top level of the sorted table search: APB register, table RAM and search sequencer.
//
//   channel   handshake             payload
//   input     start / busy          in_op, in_slot, in_value
//   result    out_valid (strobe)    out_found, out_position
//   config    APB psel/penable      paddr, pwdata, prdata (entry_count at 0x0)
//
// A write request is taken while busy is low and gives no result; busy stays low.
// A search request keeps busy high while it probes the table RAM, and on a miss also
// while it finds the range exhausted; a full table takes at most 11 probes.
// The result strobe follows in the next cycle, and a new request may be taken in it.
// The receiver cannot stall; rst_n is synchronous and does not clear the table.
`default_nettype none
module sorted_table_binary_search import stbs_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  in_op,
  input  wire logic [ADDR_W-1:0]     in_slot,
  input  wire logic [VALUE_W-1:0]    in_value,
  output logic                       out_valid,
  output logic                       out_found,
  output logic      [ADDR_W-1:0]     out_position,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  logic [COUNT_W-1:0] entry_count_r, entry_count_nxt;
  logic [COUNT_W-1:0] count_sat;
  logic               reg_sel;
  logic               accept;
  logic               wr_en;
  logic               srch_req;
  logic [ADDR_W-1:0]  rd_addr;
  logic [VALUE_W-1:0] rd_data;
  logic               srch_busy;
  logic               res_valid;
  stbs_result_t       res;

  assign reg_sel = (paddr[2] == REG_ENTRY_COUNT);

  always_comb begin
    entry_count_nxt = entry_count_r;
    if (psel && penable && pwrite && reg_sel) begin
      entry_count_nxt = pwdata[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else begin
      entry_count_r <= entry_count_nxt;
    end
  end

  assign prdata = reg_sel ? {{(CFG_DATA_W-COUNT_W){1'b0}}, entry_count_r} : '0;
  assign pready = 1'b1;

  // clamp the count to the table depth
  assign count_sat = (entry_count_r > COUNT_W'(TABLE_DEPTH)) ? COUNT_W'(TABLE_DEPTH)
                                                             : entry_count_r;

  assign accept   = start && !srch_busy;
  assign wr_en    = accept && (in_op == OP_WRITE);
  assign srch_req = accept && (in_op == OP_SEARCH);

  stbs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (in_slot),
    .wdata (in_value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  stbs_search u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (srch_req),
    .key       (in_value),
    .count     (count_sat),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .busy      (srch_busy),
    .res_valid (res_valid),
    .res       (res)
  );

  assign busy         = srch_busy;
  assign out_valid    = res_valid;
  assign out_found    = res.found;
  assign out_position = res.position;

endmodule
`default_nettype wire

[rtl/stbs_checker.sv]
// Port-level checks of the sorted table search, bound to the top level.
`default_nettype none
`include "sorted_table_binary_search_assert.svh"
module stbs_checker import stbs_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              in_op,
  input wire logic              out_valid,
  input wire logic              out_found,
  input wire logic [ADDR_W-1:0] out_position
);

  logic take_srch;
  logic take_wr;

  assign take_srch = start && !busy && (in_op == OP_SEARCH);
  assign take_wr   = start && !busy && (in_op == OP_WRITE);

  `STBS_ASSERT_NEXT(a_search_busy, take_srch, busy, "search request did not raise busy")
  `STBS_ASSERT_NEXT(a_write_silent, take_wr, !out_valid, "write request produced a result")
  `STBS_ASSERT_NOW(a_result_idle, out_valid, !busy, "result strobe while still searching")
  `STBS_ASSERT_NOW(a_miss_pos, out_valid && !out_found, out_position == '0, "miss at non-zero position")

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (.*);
`default_nettype wire
